### rtl/lfu_pkg.sv
// lfu_pkg: shared widths, constants and the structs that pass along the cell row
// and from the controller to the cells. No dependencies.
package lfu_pkg;

  localparam int USES_W    = 16;
  localparam int STAMP_W   = 32;
  localparam int ID_MAX_W  = 32;   // widest identifier any build can hold
  localparam int IDX_MAX_W = 6;    // slot index wide enough for the largest row
  localparam int REF_W     = 16;   // identifier width on the ports
  localparam int SLOT_W    = 5;    // slot_index width on the ports
  localparam int OCC_W     = 6;    // occupancy and capacity width on the ports

  localparam logic [USES_W-1:0] USES_MAX  = '1;
  localparam logic [OCC_W-1:0]  CAP_RESET = 6'd20;

  // search record handed from cell to cell, one hop a cycle
  typedef struct packed {
    logic [ID_MAX_W-1:0]  id;
    logic                 found;
    logic [IDX_MAX_W-1:0] found_idx;
    logic                 vic;
    logic [IDX_MAX_W-1:0] vic_idx;
    logic [USES_W-1:0]    vic_uses;
    logic [STAMP_W-1:0]   vic_stamp;
    logic [ID_MAX_W-1:0]  vic_ident;
    logic                 free;
    logic [IDX_MAX_W-1:0] free_idx;
  } scan_pkt_t;

  // write command broadcast to every cell
  typedef struct packed {
    logic                 inc;    // hit: bump the use count
    logic                 load;   // miss: slot takes the new identifier
    logic [IDX_MAX_W-1:0] idx;
    logic [ID_MAX_W-1:0]  id;
    logic [STAMP_W-1:0]   stamp;
  } upd_cmd_t;

endpackage

### rtl/lfu_in_if.sv
// lfu_in_if: reference channel, valid/ready with one identifier per item.
// Depends on lfu_pkg.
interface lfu_in_if;
  logic                      valid;
  logic                      ready;
  logic [lfu_pkg::REF_W-1:0] ref_id;

  modport source (output valid, output ref_id, input ready);
  modport sink   (input valid, input ref_id, output ready);
endinterface

### rtl/lfu_out_if.sv
// lfu_out_if: result channel, valid/ready with one result per item.
// Depends on lfu_pkg.
interface lfu_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic                       evicted;
  logic [lfu_pkg::REF_W-1:0]  evicted_id;
  logic [lfu_pkg::SLOT_W-1:0] slot_index;
  logic [lfu_pkg::OCC_W-1:0]  occupancy;

  modport source (output valid, output hit, output evicted, output evicted_id,
                  output slot_index, output occupancy, input ready);
  modport sink   (input valid, input hit, input evicted, input evicted_id,
                  input slot_index, input occupancy, output ready);
endinterface

### rtl/lfu_cell.sv
// lfu_cell: one slot of the row. Holds identifier, use count and stamp, folds
// itself into the passing search record and registers it for the next cell.
// Depends on lfu_pkg.
module lfu_cell #(
  parameter int CELL_IDX = 0,
  parameter int ID_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pkt_vld_in,
  input  lfu_pkg::scan_pkt_t pkt_in,
  input  lfu_pkg::upd_cmd_t  upd,
  output logic               pkt_vld_out,
  output lfu_pkg::scan_pkt_t pkt_out
);

  localparam logic [lfu_pkg::IDX_MAX_W-1:0] MY_IDX = lfu_pkg::IDX_MAX_W'(CELL_IDX);

  logic                        valid_r;
  logic [ID_BITS-1:0]          ident_r;
  logic [lfu_pkg::USES_W-1:0]  uses_r;
  logic [lfu_pkg::STAMP_W-1:0] stamp_r;

  logic                        pkt_vld_r;
  lfu_pkg::scan_pkt_t          pkt_r;
  lfu_pkg::scan_pkt_t          pkt_nxt;
  logic                        sel;

  always_comb begin
    pkt_nxt = pkt_in;
    if (valid_r) begin
      if (!pkt_in.found && (pkt_in.id[ID_BITS-1:0] == ident_r)) begin
        pkt_nxt.found     = 1'b1;
        pkt_nxt.found_idx = MY_IDX;
      end
      // lowest count wins, oldest stamp on a tie, earlier slot on a full tie
      if (!pkt_in.vic || (uses_r < pkt_in.vic_uses) ||
          ((uses_r == pkt_in.vic_uses) && (stamp_r < pkt_in.vic_stamp))) begin
        pkt_nxt.vic       = 1'b1;
        pkt_nxt.vic_idx   = MY_IDX;
        pkt_nxt.vic_uses  = uses_r;
        pkt_nxt.vic_stamp = stamp_r;
        pkt_nxt.vic_ident = lfu_pkg::ID_MAX_W'(ident_r);
      end
    end else if (!pkt_in.free) begin
      pkt_nxt.free     = 1'b1;
      pkt_nxt.free_idx = MY_IDX;
    end
  end

  assign sel = (upd.idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      pkt_vld_r <= 1'b0;
    end else begin
      pkt_vld_r <= pkt_vld_in;
      if (sel && upd.load) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pkt_r <= pkt_nxt;
    if (sel && upd.load) begin
      ident_r <= upd.id[ID_BITS-1:0];
      uses_r  <= lfu_pkg::USES_W'(1);
      stamp_r <= upd.stamp;
    end else if (sel && upd.inc && (uses_r != lfu_pkg::USES_MAX)) begin
      uses_r  <= uses_r + lfu_pkg::USES_W'(1);
    end
  end

  assign pkt_vld_out = pkt_vld_r;
  assign pkt_out     = pkt_r;

endmodule

### rtl/lfu_slot_replacement.sv
// LFU slot replacement: SLOTS cells in a row each hold one identifier with its use
// count and arrival stamp. A reference is accepted only while no other is in
// flight; its search record walks the row one cell per cycle, is captured, and
// once the output register is free or being read, the hit, free-slot or eviction
// decision is written back to the chosen cell and the result loaded into the output
// register. A result held back by out_ch.ready only delays the next item once
// that item reaches its write-back step. The stamp advances on every accepted
// item. capacity (cfg_data) is clamped to 1..SLOTS.
// Depends on lfu_pkg, lfu_in_if, lfu_out_if, lfu_cell.
module lfu_slot_replacement #(
  parameter int SLOTS   = 32,
  parameter int ID_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lfu_in_if.sink                    in_ch,
  lfu_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [lfu_pkg::OCC_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t                        state_r;
  logic [lfu_pkg::OCC_W-1:0]     cap_r;
  logic [lfu_pkg::STAMP_W-1:0]   arrival_r;
  logic [lfu_pkg::STAMP_W-1:0]   stamp_r;
  logic [CNT_W-1:0]              held_r;
  logic [CNT_W-1:0]              held_nxt;
  lfu_pkg::scan_pkt_t            res_r;

  logic                          out_valid_r;
  logic                          hit_r;
  logic                          ev_r;
  logic [lfu_pkg::REF_W-1:0]     ev_id_r;
  logic [lfu_pkg::SLOT_W-1:0]    slot_r;
  logic [lfu_pkg::OCC_W-1:0]     occ_r;

  logic                          in_acc;
  logic                          out_free;
  logic                          fin;
  logic                          take_free;
  logic [CNT_W-1:0]              cap_eff;
  logic [lfu_pkg::IDX_MAX_W-1:0] slot_sel;
  lfu_pkg::upd_cmd_t             upd;

  lfu_pkg::scan_pkt_t            pkt_chain [SLOTS+1];
  logic [SLOTS:0]                vld_chain;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    pkt_chain[0]    = '0;
    pkt_chain[0].id = lfu_pkg::ID_MAX_W'(ID_BITS'(in_ch.ref_id));
    vld_chain[0]    = in_acc;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lfu_cell #(
      .CELL_IDX (g),
      .ID_BITS  (ID_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .pkt_vld_in  (vld_chain[g]),
      .pkt_in      (pkt_chain[g]),
      .upd         (upd),
      .pkt_vld_out (vld_chain[g+1]),
      .pkt_out     (pkt_chain[g+1])
    );
  end

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > 32'(SLOTS)) begin
      cap_eff = CNT_W'(SLOTS);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  always_comb begin
    out_free  = !out_valid_r || out_ch.ready;
    fin       = (state_r == S_DONE) && out_free;
    take_free = !res_r.found && ((held_r < cap_eff) || !res_r.vic) && res_r.free;
    if (res_r.found) begin
      slot_sel = res_r.found_idx;
    end else if (take_free) begin
      slot_sel = res_r.free_idx;
    end else begin
      slot_sel = res_r.vic_idx;
    end
    upd.inc   = fin && res_r.found;
    upd.load  = fin && !res_r.found;
    upd.idx   = slot_sel;
    upd.id    = res_r.id;
    upd.stamp = stamp_r;
    held_nxt  = held_r + CNT_W'(take_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= lfu_pkg::CAP_RESET;
      arrival_r   <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            stamp_r   <= arrival_r;
            arrival_r <= arrival_r + lfu_pkg::STAMP_W'(1);
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (vld_chain[SLOTS]) begin
            res_r   <= pkt_chain[SLOTS];
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (fin) begin
            held_r  <= held_nxt;
            hit_r   <= res_r.found;
            ev_r    <= !res_r.found && !take_free;
            ev_id_r <= (!res_r.found && !take_free) ?
                       res_r.vic_ident[lfu_pkg::REF_W-1:0] : '0;
            slot_r  <= slot_sel[lfu_pkg::SLOT_W-1:0];
            occ_r   <= lfu_pkg::OCC_W'(held_nxt);
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = hit_r;
  assign out_ch.evicted    = ev_r;
  assign out_ch.evicted_id = ev_id_r;
  assign out_ch.slot_index = slot_r;
  assign out_ch.occupancy  = occ_r;

  // at most one search record in the row at a time
  a_one_pkt: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_chain[SLOTS:1]) <= 1)
    else $error("more than one search record in flight");

  // a new reference never enters while a search is still walking the row
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (vld_chain[SLOTS:1] == '0))
    else $error("reference accepted during a search");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(held_r) <= 32'(SLOTS))
    else $error("held count beyond slot count");

  // a hit leaves the occupancy unchanged
  a_hit_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && res_r.found) |=> (held_r == $past(held_r)))
    else $error("occupancy changed on a hit");

  // the search record reaches the end of the row only while scanning
  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    vld_chain[SLOTS] |-> (state_r == S_SCAN))
    else $error("search record finished outside scan");

endmodule

### tb/testbench.sv
// Self-checking bench for lfu_slot_replacement: a table of directed references,
// then random phases at several capacities, each item checked against a typed result or a local LFU model.
// Depends on lfu_pkg, lfu_in_if, lfu_out_if and the block itself.
`timescale 1ns / 100ps

module testbench;

  localparam int NSLOTS     = 32;
  localparam int CYCLE_CAP  = 400000;
  localparam int RAND_ITEMS = 500;

  typedef struct packed {
    logic                       hit;
    logic                       evicted;
    logic [lfu_pkg::REF_W-1:0]  evicted_id;
    logic [lfu_pkg::SLOT_W-1:0] slot_index;
    logic [lfu_pkg::OCC_W-1:0]  occupancy;
  } placement_t;

  typedef struct packed {
    logic                      set_cap;
    logic [lfu_pkg::OCC_W-1:0] cap;
    logic [lfu_pkg::REF_W-1:0] id;
    logic                      typed;
    placement_t                want;
  } dir_row_t;

  // typed rows follow by hand from reset; the rest are left to the model
  localparam int DIR_N = 18;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{1'b0, 6'd0,  16'h0000, 1'b1, '{1'b0, 1'b0, 16'h0000, 5'd0, 6'd1}},
    '{1'b0, 6'd0,  16'hFFFF, 1'b1, '{1'b0, 1'b0, 16'h0000, 5'd1, 6'd2}},
    '{1'b0, 6'd0,  16'h0000, 1'b1, '{1'b1, 1'b0, 16'h0000, 5'd0, 6'd2}},
    // capacity zero acts as one, and lies below occupancy
    '{1'b1, 6'd0,  16'h1234, 1'b1, '{1'b0, 1'b1, 16'hFFFF, 5'd1, 6'd2}},
    '{1'b0, 6'd0,  16'hAAAA, 1'b1, '{1'b0, 1'b1, 16'h1234, 5'd1, 6'd2}},
    '{1'b0, 6'd0,  16'h5555, 1'b1, '{1'b0, 1'b1, 16'hAAAA, 5'd1, 6'd2}},
    '{1'b0, 6'd0,  16'h5555, 1'b1, '{1'b1, 1'b0, 16'h0000, 5'd1, 6'd2}},
    '{1'b0, 6'd0,  16'h0000, 1'b1, '{1'b1, 1'b0, 16'h0000, 5'd0, 6'd2}},
    // capacity above slot count clamps to the full row
    '{1'b1, 6'd63, 16'h0001, 1'b1, '{1'b0, 1'b0, 16'h0000, 5'd2, 6'd3}},
    '{1'b0, 6'd0,  16'h0002, 1'b0, '0},
    // equal counts: oldest stamp goes first
    '{1'b1, 6'd3,  16'h0003, 1'b0, '0},
    '{1'b0, 6'd0,  16'h0004, 1'b0, '0},
    '{1'b1, 6'd33, 16'h0005, 1'b0, '0},
    '{1'b1, 6'd32, 16'hFFFF, 1'b0, '0},
    '{1'b0, 6'd0,  16'hFFFF, 1'b0, '0},
    '{1'b1, 6'd1,  16'h8000, 1'b0, '0},
    '{1'b0, 6'd0,  16'h7FFF, 1'b0, '0},
    '{1'b1, 6'd20, 16'h0000, 1'b0, '0}
  };

  localparam int PHASES = 11;
  localparam logic [lfu_pkg::OCC_W-1:0] PHASE_CAPS [PHASES] = '{
    6'd1, 6'd32, 6'd8, 6'd63, 6'd0, 6'd33, 6'd5, 6'd16, 6'd2, 6'd32, 6'd12
  };

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [lfu_pkg::OCC_W-1:0] cfg_data;

  lfu_in_if  in_ch();
  lfu_out_if out_ch();

  lfu_slot_replacement u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // local copy of the slot row
  bit                          held_valid [NSLOTS];
  logic [lfu_pkg::REF_W-1:0]   held_id    [NSLOTS];
  logic [lfu_pkg::USES_W-1:0]  held_uses  [NSLOTS];
  logic [lfu_pkg::STAMP_W-1:0] held_stamp [NSLOTS];
  logic [lfu_pkg::STAMP_W-1:0] arrivals;
  int                          held_total;
  logic [lfu_pkg::OCC_W-1:0]   cap_now;

  placement_t                  pending_placements [$];
  logic [lfu_pkg::REF_W-1:0]   id_pool [$];

  int  errors;
  int  cycle_count;
  int  n_refs;
  int  n_hits;
  int  n_evicts;
  int  n_checked;
  int  n_caps;
  bit  in_calm;
  bit  out_calm;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_placements.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic int clamp_cap(input logic [lfu_pkg::OCC_W-1:0] c);
    if (c == 0) return 1;
    if (c > NSLOTS) return NSLOTS;
    return int'(c);
  endfunction

  // use-count saturation and stamp wrap lie far beyond this run's length,
  // but the model keeps them anyway
  function automatic placement_t next_placement(input logic [lfu_pkg::REF_W-1:0] id);
    placement_t                  r;
    int                          found;
    int                          free_s;
    int                          victim;
    int                          slot;
    int                          cap;
    logic [lfu_pkg::STAMP_W-1:0] stamp;
    r      = '0;
    found  = -1;
    free_s = -1;
    victim = -1;
    slot   = 0;
    cap    = clamp_cap(cap_now);
    stamp  = arrivals;
    arrivals = arrivals + 1;
    for (int i = 0; i < NSLOTS; i++) begin
      if (held_valid[i]) begin
        if (found < 0 && held_id[i] == id) found = i;
        if (victim < 0 || held_uses[i] < held_uses[victim] ||
            (held_uses[i] == held_uses[victim] && held_stamp[i] < held_stamp[victim]))
          victim = i;
      end else if (free_s < 0) begin
        free_s = i;
      end
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      slot  = found;
      if (held_uses[found] != lfu_pkg::USES_MAX) held_uses[found] = held_uses[found] + 1;
    end else begin
      if ((held_total < cap || victim < 0) && free_s >= 0) begin
        slot = free_s;
        held_valid[slot] = 1'b1;
        held_total++;
      end else if (victim >= 0) begin
        slot         = victim;
        r.evicted    = 1'b1;
        r.evicted_id = held_id[victim];
      end
      held_id[slot]    = id;
      held_uses[slot]  = 1;
      held_stamp[slot] = stamp;
    end
    r.slot_index = lfu_pkg::SLOT_W'(slot);
    r.occupancy  = lfu_pkg::OCC_W'(held_total);
    return r;
  endfunction

  function automatic int pick_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  task automatic send_ref(input logic [lfu_pkg::REF_W-1:0] id, input bit typed,
                          input placement_t typed_want);
    int         gap;
    placement_t p;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.ref_id <= id;
    do @(posedge clk); while (!in_ch.ready);
    p = next_placement(id);
    n_refs++;
    n_hits   += p.hit;
    n_evicts += p.evicted;
    pending_placements.push_back(typed ? typed_want : p);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [lfu_pkg::OCC_W-1:0] c);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_now  = c;
    n_caps++;
  endtask

  function automatic logic [lfu_pkg::REF_W-1:0] pick_id();
    if ($urandom_range(0, 99) < 12) return lfu_pkg::REF_W'($urandom);
    // skewed towards the head of the pool so counts build up unevenly
    return id_pool[$urandom_range(0, $urandom_range(0, id_pool.size() - 1))];
  endfunction

  // result side
  initial begin
    int         stall;
    placement_t want;
    placement_t got;
    @(posedge rst_n);
    forever begin
      stall = pick_gap(out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = '{out_ch.hit, out_ch.evicted, out_ch.evicted_id, out_ch.slot_index,
              out_ch.occupancy};
      if (pending_placements.size() == 0) begin
        report_mismatch($sformatf("result %p with nothing pending", got));
      end else begin
        want = pending_placements.pop_front();
        n_checked++;
        if (got.hit !== want.hit)
          report_mismatch($sformatf("hit got %0b want %0b", got.hit, want.hit));
        if (got.evicted !== want.evicted)
          report_mismatch($sformatf("evicted got %0b want %0b", got.evicted, want.evicted));
        if (got.evicted_id !== want.evicted_id)
          report_mismatch($sformatf("evicted_id got %h want %h", got.evicted_id,
                                    want.evicted_id));
        if (got.slot_index !== want.slot_index)
          report_mismatch($sformatf("slot_index got %0d want %0d", got.slot_index,
                                    want.slot_index));
        if (got.occupancy !== want.occupancy)
          report_mismatch($sformatf("occupancy got %0d want %0d", got.occupancy,
                                    want.occupancy));
      end
    end
  end

  // stimulus
  initial begin
    int per_phase;
    int pool_n;
    int eff;
    in_ch.valid  <= 1'b0;
    in_ch.ref_id <= '0;
    out_ch.ready <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_data     <= '0;
    rst_n        <= 1'b0;
    errors      = 0;
    cycle_count = 0;
    n_refs      = 0;
    n_hits      = 0;
    n_evicts    = 0;
    n_checked   = 0;
    n_caps      = 0;
    in_calm     = 1'b0;
    out_calm    = 1'b0;
    arrivals    = '0;
    held_total  = 0;
    cap_now     = lfu_pkg::CAP_RESET;
    for (int i = 0; i < NSLOTS; i++) begin
      held_valid[i] = 1'b0;
      held_id[i]    = '0;
      held_uses[i]  = '0;
      held_stamp[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      if (DIR_ROWS[r].set_cap) set_capacity(DIR_ROWS[r].cap);
      send_ref(DIR_ROWS[r].id, DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    per_phase = RAND_ITEMS / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      set_capacity(PHASE_CAPS[ph]);
      eff    = clamp_cap(PHASE_CAPS[ph]);
      pool_n = eff + $urandom_range(1, eff + 4);
      id_pool.delete();
      repeat (pool_n) id_pool.push_back(lfu_pkg::REF_W'($urandom));
      // some phases run flat out on one side or both
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      repeat (per_phase) send_ref(pick_id(), 1'b0, '0);
    end

    wait_idle();
    repeat (2 * (NSLOTS + 2)) @(posedge clk);
    $display("%0d references checked (%0d results), %0d hits, %0d evictions",
             n_refs, n_checked, n_hits, n_evicts);
    $display("%0d capacity writes, clamp and below-occupancy cases included", n_caps);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
